>>> rtl/length_prefixed_record_deframer_macros.svh
// Assertion helpers shared by the deframer RTL.
// Each helper is clocked on the rising edge and is disabled while reset is low.
`ifndef LENGTH_PREFIXED_RECORD_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lprd_pkg.sv
`default_nettype none

package lprd_pkg;

  // Field widths.
  localparam int LENGTH_WIDTH  = 31;
  localparam int COUNT_WIDTH   = 16;
  localparam int CFG_WIDTH     = 16;
  localparam int BYTE_WIDTH    = 8;
  localparam int HDR_BITS      = 7;
  localparam int MAX_HDR_BYTES = (LENGTH_WIDTH + HDR_BITS - 1) / HDR_BITS;
  localparam int HCNT_WIDTH    = $clog2(MAX_HDR_BYTES + 1);
  localparam int SHIFT_WIDTH   = $clog2(HDR_BITS * MAX_HDR_BYTES);
  localparam int CMP_WIDTH     = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam logic [CFG_WIDTH-1:0] MAX_RECORDS_RESET = '1;

  // Parser phase codes.
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_IGNORE  = 2'd2;

  // Byte role codes.
  localparam logic [1:0] ROLE_HEADER  = 2'd0;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd1;
  localparam logic [1:0] ROLE_IGNORE  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TRUNC_HDR   = 2'd1;
  localparam logic [1:0] ST_TRUNC_PAYLD = 2'd2;
  localparam logic [1:0] ST_OVERFLOW    = 2'd3;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0] in_byte;
    logic                  buffer_last;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0]   data_byte;
    logic [1:0]              byte_role;
    logic                    header_done;
    logic [LENGTH_WIDTH-1:0] record_length;
    logic                    record_end;
    logic [COUNT_WIDTH-1:0]  record_index;
    logic [1:0]              status;
    logic [COUNT_WIDTH-1:0]  records_done;
  } res_beat_t;

endpackage

`default_nettype wire

>>> rtl/lprd_ifs.sv
`default_nettype none

interface lprd_in_if;
  import lprd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [BYTE_WIDTH-1:0] in_byte;
  logic                  buffer_last;

  modport source (output valid, output in_byte, output buffer_last, input ready);
  modport sink   (input valid, input in_byte, input buffer_last, output ready);
endinterface

interface lprd_out_if;
  import lprd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BYTE_WIDTH-1:0]   data_byte;
  logic [1:0]              byte_role;
  logic                    header_done;
  logic [LENGTH_WIDTH-1:0] record_length;
  logic                    record_end;
  logic [COUNT_WIDTH-1:0]  record_index;
  logic [1:0]              status;
  logic [COUNT_WIDTH-1:0]  records_done;

  modport source (
    output valid, output data_byte, output byte_role, output header_done,
    output record_length, output record_end, output record_index,
    output status, output records_done, input ready
  );
  modport sink (
    input valid, input data_byte, input byte_role, input header_done,
    input record_length, input record_end, input record_index,
    input status, input records_done, output ready
  );
endinterface

`default_nettype wire

>>> rtl/lprd_in_stage.sv
`default_nettype none

module lprd_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire lprd_pkg::in_beat_t beat_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output lprd_pkg::in_beat_t     beat_o
);
  import lprd_pkg::*;

  logic     valid_q;
  in_beat_t beat_q;

  // The register refills in the same cycle it is drained.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lprd_out_stage.sv
`default_nettype none

module lprd_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire lprd_pkg::res_beat_t res_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output lprd_pkg::res_beat_t     res_o
);
  import lprd_pkg::*;

  logic      valid_q;
  res_beat_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lprd_core.sv
`default_nettype none

`include "length_prefixed_record_deframer_macros.svh"

module lprd_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lprd_pkg::CFG_WIDTH-1:0] cfg_data_i,
  input  wire logic                           valid_i,
  output logic                                ready_o,
  input  wire lprd_pkg::in_beat_t             beat_i,
  output logic                                valid_o,
  input  wire logic                           ready_i,
  output lprd_pkg::res_beat_t                 res_o
);
  import lprd_pkg::*;

  logic [CFG_WIDTH-1:0]    max_q;
  logic [1:0]              phase_q, phase_d;
  logic [LENGTH_WIDTH-1:0] acc_q, acc_d;
  logic [HCNT_WIDTH-1:0]   hcnt_q, hcnt_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic                    fire;

  logic [SHIFT_WIDTH-1:0]          shamt;
  logic [LENGTH_WIDTH+HDR_BITS-1:0] shifted;
  logic [LENGTH_WIDTH-1:0]         acc_new;
  logic [LENGTH_WIDTH-1:0]         rem_dec;
  logic [COUNT_WIDTH-1:0]          cnt_inc;
  logic                            at_limit;

  // The item moves straight into the result register; no bubble is needed.
  assign ready_o = ready_i;
  assign valid_o = valid_i;
  assign fire    = valid_i && ready_i;

  assign shamt   = SHIFT_WIDTH'(hcnt_q) * SHIFT_WIDTH'(HDR_BITS);
  assign shifted = {{LENGTH_WIDTH{1'b0}}, beat_i.in_byte[HDR_BITS-1:0]} << shamt;
  assign acc_new = acc_q | shifted[LENGTH_WIDTH-1:0];
  assign rem_dec = (rem_q == '0) ? rem_q : rem_q - LENGTH_WIDTH'(1);
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
  assign at_limit = CMP_WIDTH'(cnt_q) >= CMP_WIDTH'(max_q);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    hcnt_d  = hcnt_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;

    res_o              = '0;
    res_o.data_byte    = beat_i.in_byte;
    res_o.byte_role    = ROLE_IGNORE;
    res_o.record_index = cnt_q;
    res_o.status       = ST_OK;

    if (phase_q == PH_HEADER && at_limit) begin
      phase_d = PH_IGNORE;
    end

    case (phase_d)
      PH_HEADER: begin
        res_o.byte_role = ROLE_HEADER;
        if (hcnt_q >= HCNT_WIDTH'(MAX_HDR_BYTES) ||
            (|shifted[LENGTH_WIDTH+HDR_BITS-1:LENGTH_WIDTH])) begin
          res_o.status = ST_OVERFLOW;
          phase_d      = PH_IGNORE;
        end else if (beat_i.in_byte[BYTE_WIDTH-1]) begin
          res_o.header_done   = 1'b1;
          res_o.record_length = acc_new;
          acc_d  = '0;
          hcnt_d = '0;
          if (acc_new == '0) begin
            res_o.record_end = 1'b1;
            cnt_d            = cnt_inc;
          end else begin
            rem_d   = acc_new;
            phase_d = PH_PAYLOAD;
            if (beat_i.buffer_last) begin
              res_o.status = ST_TRUNC_PAYLD;
            end
          end
        end else begin
          acc_d  = acc_new;
          hcnt_d = hcnt_q + HCNT_WIDTH'(1);
          if (beat_i.buffer_last) begin
            res_o.status = ST_TRUNC_HDR;
          end
        end
      end
      PH_PAYLOAD: begin
        res_o.byte_role = ROLE_PAYLOAD;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          res_o.record_end = 1'b1;
          cnt_d            = cnt_inc;
          phase_d          = PH_HEADER;
        end else if (beat_i.buffer_last) begin
          res_o.status = ST_TRUNC_PAYLD;
        end
      end
      default: begin
        phase_d = PH_IGNORE;
      end
    endcase

    res_o.records_done = cnt_d;

    // The end of a buffer returns the parser to its reset state.
    if (beat_i.buffer_last) begin
      phase_d = PH_HEADER;
      acc_d   = '0;
      hcnt_d  = '0;
      rem_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= MAX_RECORDS_RESET;
      phase_q <= PH_HEADER;
      acc_q   <= '0;
      hcnt_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        hcnt_q  <= hcnt_d;
        rem_q   <= rem_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  `LPRD_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, fire && beat_i.buffer_last,
                    phase_q == PH_HEADER && cnt_q == '0 && hcnt_q == '0 && acc_q == '0,
                    "parser state not cleared after buffer end")
  `LPRD_ASSERT_SAME(a_payload_nonzero, clk_i, rst_ni, phase_q == PH_PAYLOAD,
                    rem_q != '0, "payload phase with nothing remaining")
  `LPRD_ASSERT_SAME(a_hcnt_bound, clk_i, rst_ni, 1'b1,
                    hcnt_q <= HCNT_WIDTH'(MAX_HDR_BYTES), "header byte count out of range")
  `LPRD_ASSERT_NEXT(a_count_step, clk_i, rst_ni, fire && !beat_i.buffer_last,
                    cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + COUNT_WIDTH'(1),
                    "record count moved by more than one")

endmodule

`default_nettype wire

>>> rtl/length_prefixed_record_deframer.sv
// A beat is captured in the input register, parsed by the combinational core and
// then held in the output register, from which its result is taken.
// Throughput: one beat per cycle, sustained while the output side takes beats.
// Reset: rst_ni clears the parser state and both stage registers at once and
// sets max_records to 65535; there is no clearing pass.
`default_nettype none

module length_prefixed_record_deframer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lprd_pkg::CFG_WIDTH-1:0] cfg_data_i,
  lprd_in_if.sink                             in_if,
  lprd_out_if.source                          out_if
);
  import lprd_pkg::*;

  // The design is three short pieces in a line. An input register takes the
  // incoming beat and decouples the upstream ready from the parse logic. The
  // parser core holds the phase, the header accumulator, the payload down
  // counter and the record count, and in one pass of combinational logic
  // turns the registered byte into a tagged result and the next state. The
  // output register holds the result until the downstream side takes it. A
  // new byte is parsed in the same cycle that the previous result is taken,
  // and while the downstream side holds off the stall reaches back to the
  // input side.

  in_beat_t  in_beat;
  in_beat_t  stg_beat;
  logic      stg_valid;
  logic      stg_ready;
  res_beat_t core_res;
  logic      core_valid;
  logic      core_ready;
  res_beat_t out_res;

  assign in_beat.in_byte     = in_if.in_byte;
  assign in_beat.buffer_last = in_if.buffer_last;

  lprd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_if.valid),
    .ready_o (in_if.ready),
    .beat_i  (in_beat),
    .valid_o (stg_valid),
    .ready_i (stg_ready),
    .beat_o  (stg_beat)
  );

  // The core updates its state only when the result register accepts the
  // beat, so a stalled output holds the parser exactly where it is.
  lprd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (stg_valid),
    .ready_o    (stg_ready),
    .beat_i     (stg_beat),
    .valid_o    (core_valid),
    .ready_i    (core_ready),
    .res_o      (core_res)
  );

  lprd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_valid),
    .ready_o (core_ready),
    .res_i   (core_res),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .res_o   (out_res)
  );

  // Unpack the registered result onto the output channel.
  assign out_if.data_byte     = out_res.data_byte;
  assign out_if.byte_role     = out_res.byte_role;
  assign out_if.header_done   = out_res.header_done;
  assign out_if.record_length = out_res.record_length;
  assign out_if.record_end    = out_res.record_end;
  assign out_if.record_index  = out_res.record_index;
  assign out_if.status        = out_res.status;
  assign out_if.records_done  = out_res.records_done;

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lprd_pkg::*;

  // Header byte layout: the low seven bits carry length bits, the top bit marks the final byte.
  localparam logic [7:0] HDR_FINAL = 8'h80;
  localparam logic [7:0] HDR_BITS  = 8'h7F;
  localparam int HDR_BITS_W = 7;

  // Receiver hold-off that backs the block up until it stalls its input side.
  localparam int LONG_HOLD = 80;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_WIDTH-1:0] cfg_data_i;

  lprd_in_if  in_if ();
  lprd_out_if out_if ();

  length_prefixed_record_deframer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to be offered, and the tagged bytes the block still owes us.
  in_beat_t  pending_bytes[$];
  res_beat_t expected_tags[$];

  int  beats_queued;
  int  mismatches;
  int  tags_seen;
  int  src_gap;
  int  snk_wait;
  bit  src_idle_on;
  bit  snk_idle_on;
  in_beat_t next_beat;
  res_beat_t got_tag;
  res_beat_t want_tag;

  // Shadow of the parser state and of the record limit register.
  logic [1:0]              parse_phase;
  logic [LENGTH_WIDTH-1:0] length_sum;
  int                      hdr_bytes;
  logic [LENGTH_WIDTH-1:0] payload_left;
  logic [COUNT_WIDTH-1:0]  record_count;
  logic [CFG_WIDTH-1:0]    max_records_cfg;

  function automatic void clear_parse();
    parse_phase  = PH_HEADER;
    length_sum   = '0;
    hdr_bytes    = 0;
    payload_left = '0;
    record_count = '0;
  endfunction

  function automatic void bump_records();
    if (record_count != '1) begin
      record_count = record_count + 1'b1;
    end
  endfunction

  // Works out the tag of one source byte and advances the shadow parser.
  function automatic res_beat_t deframe_byte(logic [7:0] b, logic last);
    res_beat_t   tag;
    logic [63:0] bits;
    int          shift;
    tag              = '0;
    tag.data_byte    = b;
    tag.byte_role    = ROLE_IGNORE;
    tag.status       = ST_OK;
    tag.record_index = record_count;
    bits             = 64'(b & HDR_BITS);

    // Once the record limit is reached, the rest of the buffer is skipped.
    if (parse_phase == PH_HEADER && record_count >= max_records_cfg) begin
      parse_phase = PH_IGNORE;
    end

    if (parse_phase == PH_HEADER) begin
      tag.byte_role = ROLE_HEADER;
      shift         = HDR_BITS_W * hdr_bytes;
      // A header longer than the length field can hold, or one whose bits land at or
      // above the top of the field, is an overflow; nothing more of this buffer is parsed.
      if (hdr_bytes >= MAX_HDR_BYTES || (bits >> (LENGTH_WIDTH - shift)) != 0) begin
        tag.status  = ST_OVERFLOW;
        parse_phase = PH_IGNORE;
      end else begin
        length_sum = length_sum | LENGTH_WIDTH'(bits << shift);
        hdr_bytes++;
        if (b[7]) begin
          tag.header_done   = 1'b1;
          tag.record_length = length_sum;
          if (length_sum == '0) begin
            tag.record_end = 1'b1;
            bump_records();
          end else begin
            payload_left = length_sum;
            parse_phase  = PH_PAYLOAD;
            if (last) begin
              tag.status = ST_TRUNC_PAYLD;
            end
          end
          length_sum = '0;
          hdr_bytes  = 0;
        end else if (last) begin
          tag.status = ST_TRUNC_HDR;
        end
      end
    end else if (parse_phase == PH_PAYLOAD) begin
      tag.byte_role = ROLE_PAYLOAD;
      if (payload_left != '0) begin
        payload_left = payload_left - 1'b1;
      end
      if (payload_left == '0) begin
        tag.record_end = 1'b1;
        bump_records();
        parse_phase = PH_HEADER;
      end else if (last) begin
        tag.status = ST_TRUNC_PAYLD;
      end
    end

    tag.records_done = record_count;
    if (last) begin
      clear_parse();
    end
    return tag;
  endfunction

  // Sender: each byte is followed by a random number of idle cycles when idling is on.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.in_byte     <= '0;
      in_if.buffer_last <= 1'b0;
      src_gap           = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_tags.push_back(deframe_byte(in_if.in_byte, in_if.buffer_last));
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap != 0) begin
          in_if.valid <= 1'b0;
          src_gap     = src_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          next_beat         = pending_bytes.pop_front();
          in_if.valid       <= 1'b1;
          in_if.in_byte     <= next_beat.in_byte;
          in_if.buffer_last <= next_beat.buffer_last;
          src_gap           = src_idle_on ? int'($urandom_range(0, 11)) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: checks every tagged byte against the oldest prediction. Now and then it
  // holds ready low for a long stretch so that the block fills and pushes back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_wait     = 0;
      tags_seen    = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_tag = '{out_if.data_byte, out_if.byte_role, out_if.header_done,
                    out_if.record_length, out_if.record_end, out_if.record_index,
                    out_if.status, out_if.records_done};
        if (expected_tags.size() == 0) begin
          $error("tagged byte 0x%0h arrived with no prediction pending", out_if.data_byte);
          mismatches++;
        end else begin
          want_tag = expected_tags.pop_front();
          compare_field("data_byte", 64'(want_tag.data_byte), 64'(got_tag.data_byte));
          compare_field("byte_role", 64'(want_tag.byte_role), 64'(got_tag.byte_role));
          compare_field("header_done", 64'(want_tag.header_done), 64'(got_tag.header_done));
          compare_field("record_length", 64'(want_tag.record_length),
                        64'(got_tag.record_length));
          compare_field("record_end", 64'(want_tag.record_end), 64'(got_tag.record_end));
          compare_field("record_index", 64'(want_tag.record_index),
                        64'(got_tag.record_index));
          compare_field("status", 64'(want_tag.status), 64'(got_tag.status));
          compare_field("records_done", 64'(want_tag.records_done),
                        64'(got_tag.records_done));
        end
        tags_seen++;
        if (tags_seen % 500 == 250) begin
          snk_wait = LONG_HOLD;
        end else begin
          snk_wait = snk_idle_on ? int'($urandom_range(0, 11)) : 0;
        end
      end
      if (snk_wait != 0) begin
        out_if.ready <= 1'b0;
        snk_wait     = snk_wait - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_byte(logic [7:0] b);
    in_beat_t beat;
    beat.in_byte     = b;
    beat.buffer_last = 1'b0;
    pending_bytes.push_back(beat);
    beats_queued++;
  endtask

  // Closes the buffer: its final byte carries the buffer end flag.
  task automatic close_buffer();
    in_beat_t beat;
    beat             = pending_bytes.pop_back();
    beat.buffer_last = 1'b1;
    pending_bytes.push_back(beat);
  endtask

  // Emits a length header, optionally padded with zero-valued groups up to the widest form.
  task automatic add_header(int unsigned len, bit pad);
    int n_min;
    int n_used;
    n_min = 1;
    while (n_min < MAX_HDR_BYTES && (len >> (HDR_BITS_W * n_min)) != 0) begin
      n_min++;
    end
    n_used = pad ? int'($urandom_range(n_min, MAX_HDR_BYTES)) : n_min;
    for (int i = 0; i < n_used; i++) begin
      add_byte(8'((len >> (HDR_BITS_W * i)) & HDR_BITS) | ((i == n_used - 1) ? HDR_FINAL : 8'h00));
    end
  endtask

  task automatic add_junk(int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  // One buffer: mostly well-formed records with random content, sometimes ending in a
  // broken record, and now and then plain noise.
  task automatic gen_buffer();
    int unsigned len;
    if ($urandom_range(0, 9) == 0) begin
      add_junk($urandom_range(1, 12));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1:    len = 0;
          9:       len = $urandom_range(9, 40);
          default: len = $urandom_range(1, 8);
        endcase
        add_header(len, $urandom_range(0, 4) == 0);
        add_junk(len);
      end
      case ($urandom_range(0, 9))
        0: begin
          // Header cut off by the buffer end.
          repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 127)));
        end
        1: begin
          // Overflow, either by header length or by bits past the top of the field.
          if ($urandom_range(0, 1) == 1) begin
            repeat (MAX_HDR_BYTES) add_byte(8'($urandom_range(0, 127)));
            add_byte(8'($urandom_range(0, 255)));
          end else begin
            repeat (MAX_HDR_BYTES - 1) add_byte(8'($urandom_range(0, 127)));
            add_byte(8'($urandom_range(8, 127)) | ($urandom_range(0, 1) ? HDR_FINAL : 8'h00));
          end
          add_junk($urandom_range(0, 3));
        end
        2: begin
          // Very long record that the buffer cannot hold.
          add_header($urandom() & 32'h7FFF_FFFF, $urandom_range(0, 1) == 1);
          add_junk($urandom_range(0, 4));
        end
        3: begin
          len = $urandom_range(5, 12);
          add_header(len, 1'b0);
          add_junk($urandom_range(0, len - 1));
        end
        default: ;
      endcase
    end
    close_buffer();
  endtask

  task automatic write_max_records(logic [CFG_WIDTH-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    max_records_cfg = value;
  endtask

  // The sender stops offering until every predicted byte has come back. Checked on the
  // falling edge so that no update of the rising edge is half seen.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_if.valid || expected_tags.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] limits[10];
    int                   target;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= '0;
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    mismatches  = 0;
    beats_queued = 0;
    clear_parse();
    max_records_cfg = MAX_RECORDS_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed buffers under the reset limit.
    // Empty record, a three-byte record, and an empty record in padded form.
    add_byte(8'h80);
    add_byte(8'h83); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h55);
    add_byte(8'h00); add_byte(8'h80);
    close_buffer();
    // Header cut off by the buffer end.
    add_byte(8'h7F);
    close_buffer();
    // Largest length, header ends the buffer: payload truncated.
    add_byte(8'h7F); add_byte(8'h7F); add_byte(8'h7F); add_byte(8'h7F); add_byte(8'h87);
    close_buffer();
    // Bits past the top of the length field, then ignored bytes.
    add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h88);
    add_byte(8'h12); add_byte(8'hFF);
    close_buffer();
    // One header byte too many, even though it carries no bits.
    repeat (MAX_HDR_BYTES) add_byte(8'h00);
    add_byte(8'h80);
    close_buffer();
    // Payload cut off by the buffer end.
    add_byte(8'h83); add_byte(8'h01);
    close_buffer();
    wait_drained();

    // Random phases across limit settings, extremes included, with varied idling.
    limits = '{16'd0, 16'd1, 16'd3, 16'd2, 16'hFFFF, 16'($urandom_range(0, 65535)),
               16'd4, 16'd1, 16'($urandom_range(4, 9)), 16'hFFFF};
    for (int p = 0; p < 10; p++) begin
      write_max_records(limits[p]);
      @(negedge clk_i);
      src_idle_on = (p % 3 != 0);
      snk_idle_on = (p % 4 != 1);
      target = beats_queued + 150;
      while (beats_queued < target) begin
        gen_buffer();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
